### rtl/wssa_pkg.sv
// Shared types and constants for the weighted source slot arbiter.
package wssa_pkg;

    localparam int NUM_INPUT_BITS = 8;

    localparam logic [31:0] WEIGHTS_RESET   = 32'h9553_3115;
    localparam logic [4:0]  LAST_LINE_RESET = 5'd16;

    // configuration register indexes
    localparam logic CFG_SOURCE_WEIGHTS = 1'b0;
    localparam logic CFG_LAST_LINE      = 1'b1;

    // slot outcomes
    localparam logic [2:0] OUT_MOVED_ROW     = 3'd0;
    localparam logic [2:0] OUT_MOVED_HEADER  = 3'd1;
    localparam logic [2:0] OUT_DEST_FULL     = 3'd2;
    localparam logic [2:0] OUT_SOURCE_EMPTY  = 3'd3;
    localparam logic [2:0] OUT_SOURCE_HELD   = 3'd4;

    typedef struct packed {
        logic [NUM_INPUT_BITS-1:0] source_ready;
        logic [NUM_INPUT_BITS-1:0] head_is_header;
        logic                      dest_full;
    } t_in_item;

    typedef struct packed {
        logic [2:0] chosen_source;
        logic [2:0] outcome;
        logic [4:0] line_number;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic load;     // latch the accepted request
        logic step;     // one ring step: decrement and advance
        logic commit;   // settle the slot and load the result register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic cd_zero;  // countdown of the current source reads zero
    } t_status;

endpackage

### rtl/wssa_ctrl.sv
// Slot controller: request acceptance, ring walk sequencing, result valid.
module wssa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  wssa_pkg::t_status i_status,
    output wssa_pkg::t_cmd    o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WALK = 1'b1;

    logic r_state;
    logic n_state;
    logic r_out_valid;
    logic n_out_valid;
    logic out_free;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state      = r_state;
        o_cmd.load   = 1'b0;
        o_cmd.step   = 1'b0;
        o_cmd.commit = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_WALK;
                end
            end
            ST_WALK: begin
                if (!i_status.cd_zero) begin
                    o_cmd.step = 1'b1;
                end else if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_stall) begin
            n_out_valid = r_out_valid;
        end else begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### rtl/wssa_dp.sv
// Arbiter datapath: countdowns, holds, line counter, ring pointer, result register.
module wssa_dp #(
    parameter int NUM_SOURCES = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  wssa_pkg::t_cmd       i_cmd,
    output wssa_pkg::t_status    o_status,
    input  wssa_pkg::t_in_item   i_in_item,
    input  logic [31:0]          i_weights,
    input  logic [4:0]           i_last_line,
    output wssa_pkg::t_out_item  o_out_item
);

    localparam int SW = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
    localparam logic [SW-1:0] LAST_SRC = SW'(NUM_SOURCES - 1);

    logic [3:0]          r_cd [NUM_SOURCES];
    logic [NUM_SOURCES-1:0] r_hold;
    logic [NUM_SOURCES-1:0] n_hold;
    logic [4:0]          r_line;
    logic [4:0]          n_line;
    logic [SW-1:0]       r_cur;
    logic [SW-1:0]       next_cur;
    wssa_pkg::t_in_item  r_item;
    wssa_pkg::t_out_item r_out;
    wssa_pkg::t_out_item n_out;

    logic [3:0]  cur_cd;
    logic [4:0]  cur_ext;
    logic        in_range;
    logic        src_ready;
    logic        src_header;
    logic        wrap;
    logic        held;
    logic [3:0]  cur_weight;
    logic [2:0]  outcome;

    assign cur_cd           = r_cd[r_cur];
    assign o_status.cd_zero = (cur_cd == 4'd0);
    assign next_cur         = (r_cur == LAST_SRC) ? '0 : r_cur + SW'(1);

    // sources past eight see no ready or header bits and reuse weight nibble s mod 8
    assign cur_ext    = 5'(r_cur);
    assign in_range   = (cur_ext[4:3] == 2'b00);
    assign src_ready  = in_range && r_item.source_ready[cur_ext[2:0]];
    assign src_header = in_range && r_item.head_is_header[cur_ext[2:0]];
    assign cur_weight = i_weights[{cur_ext[2:0], 2'b00} +: 4];

    assign wrap = !(r_line < i_last_line);
    assign held = !wrap && r_hold[r_cur];

    always_comb begin
        n_line = wrap ? 5'd0 : r_line + 5'd1;
        n_hold = wrap ? '0 : r_hold;
        priority if (held) begin
            outcome = wssa_pkg::OUT_SOURCE_HELD;
        end else if (r_item.dest_full) begin
            outcome = wssa_pkg::OUT_DEST_FULL;
        end else if (!src_ready) begin
            outcome = wssa_pkg::OUT_SOURCE_EMPTY;
        end else if (src_header) begin
            outcome       = wssa_pkg::OUT_MOVED_HEADER;
            n_hold[r_cur] = 1'b1;
        end else begin
            outcome = wssa_pkg::OUT_MOVED_ROW;
        end
        n_out.chosen_source = cur_ext[2:0];
        n_out.outcome       = outcome;
        n_out.line_number   = n_line;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_SOURCES; s++) begin
                r_cd[s] <= wssa_pkg::WEIGHTS_RESET[4 * (s & 7) +: 4];
            end
            r_hold <= '0;
            r_line <= 5'd0;
            r_cur  <= '0;
        end else if (i_cmd.step) begin
            r_cd[r_cur] <= cur_cd - 4'd1;
            r_cur       <= next_cur;
        end else if (i_cmd.commit) begin
            r_cd[r_cur] <= cur_weight;
            r_hold      <= n_hold;
            r_line      <= n_line;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_item;
        end
        if (i_cmd.commit) begin
            r_out <= n_out;
        end
    end

    assign o_out_item = r_out;

endmodule

### rtl/weighted_source_slot_arbiter.sv
// Top level of the weighted source slot arbiter: configuration registers and wiring.
//
// Each request on the input channel (i_in_valid / o_in_stall, payload i_in_item) is one
// packet slot. The arbiter walks the source ring from the last-served source, lowering
// each nonzero countdown, and takes the first source whose countdown is zero. It then
// steps the line counter, applies hold and full/empty rules, reloads the served
// countdown and returns one result on the output channel (o_out_valid / i_out_stall,
// payload o_out_item).
// Sequence: the request is taken, the walk steps along the ring through the single
// shared countdown decrementer, and then the slot is settled. One request is in
// flight at a time; the next is taken the cycle after the result is loaded, even
// while that result still waits.
// A stalled result holds in the output register; the walk finishes and then waits
// for the register to free up before settling the slot.
// Configuration (i_cfg_valid / o_cfg_ready, always ready): index 0 source weights,
// index 1 last line. Write only while idle.
// Reset (synchronous, active low) loads countdowns from the reset weights, clears holds,
// line counter and ring pointer, and sets weights 0x95533115 and last line 16.
module weighted_source_slot_arbiter #(
    parameter int NUM_SOURCES = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  wssa_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output wssa_pkg::t_out_item o_out_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_index,
    input  logic [31:0]         i_cfg_data
);

    logic [31:0]       r_weights;
    logic [4:0]        r_last_line;
    wssa_pkg::t_cmd    cmd;
    wssa_pkg::t_status status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weights   <= wssa_pkg::WEIGHTS_RESET;
            r_last_line <= wssa_pkg::LAST_LINE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                wssa_pkg::CFG_SOURCE_WEIGHTS: r_weights   <= i_cfg_data;
                wssa_pkg::CFG_LAST_LINE:      r_last_line <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    wssa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    wssa_dp #(
        .NUM_SOURCES (NUM_SOURCES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_item   (i_in_item),
        .i_weights   (r_weights),
        .i_last_line (r_last_line),
        .o_out_item  (o_out_item)
    );

endmodule
